// File: hdl/full_search_block_match_unit_assert.svh
// assertion macros for the full search block match unit
`ifndef FULL_SEARCH_BLOCK_MATCH_UNIT_ASSERT_SVH
`define FULL_SEARCH_BLOCK_MATCH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define FSBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define FSBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define FSBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FSBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/fsbm_pkg.sv
// shared constants, codes and types of the full search block match unit
`default_nettype none

package fsbm_pkg;

    localparam int DEF_FRAME_WIDTH  = 640;
    localparam int DEF_FRAME_HEIGHT = 360;
    localparam int DEF_BLOCK_SIZE   = 8;

    localparam int INITIAL_BEST = 16500;

    localparam int PIXEL_W     = 8;
    localparam int PIXEL_MAX   = (1 << PIXEL_W) - 1;
    localparam int CMD_W       = 2;
    localparam int PIXEL_ROW_W = 9;
    localparam int PIXEL_COL_W = 10;
    localparam int BLOCK_ROW_W = 6;
    localparam int BLOCK_COL_W = 7;
    localparam int MATCH_ROW_W = 9;
    localparam int MATCH_COL_W = 10;
    localparam int BLOCK_NUM_W = 12;

    localparam logic [CMD_W-1:0] CMD_WR_REF = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_CUR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    function automatic int clog2_min1(input int x);
        return (x > 1) ? $clog2(x) : 1;
    endfunction

    typedef struct packed {
        logic load;
        logic wr_commit;
        logic scan_issue;
        logic out_load;
    } t_fsbm_cmd;

    typedef struct packed {
        logic wr_go;
        logic srch_go;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } t_fsbm_status;

endpackage

`default_nettype wire

// File: hdl/fsbm_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module fsbm_ram #(
    parameter int WIDTH = fsbm_pkg::PIXEL_W,
    parameter int DEPTH = fsbm_pkg::DEF_FRAME_WIDTH
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [fsbm_pkg::clog2_min1(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [fsbm_pkg::clog2_min1(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/fsbm_ctrl.sv
// sequencer for pixel writes and block searches
`default_nettype none

`include "full_search_block_match_unit_assert.svh"

module fsbm_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire fsbm_pkg::t_fsbm_status i_status,
    output fsbm_pkg::t_fsbm_cmd         o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WRITE = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.wr_go) begin
                        n_state = ST_WRITE;
                    end else if (i_status.srch_go) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_WRITE: begin
                o_cmd.wr_commit = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy && i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
        endcase
    end

    `FSBM_ASSERT_IMP(a_cmd_exclusive, i_clk, i_rst_n, 1'b1,
        $onehot0({o_cmd.load, o_cmd.wr_commit, o_cmd.scan_issue, o_cmd.out_load}))
    `FSBM_ASSERT_NEXT(a_scan_stops, i_clk, i_rst_n,
        o_cmd.scan_issue && i_status.scan_last, !o_cmd.scan_issue)
    `FSBM_ASSERT_NEXT(a_search_starts, i_clk, i_rst_n,
        o_cmd.load && i_status.srch_go, o_cmd.scan_issue && !o_ready)

endmodule

`default_nettype wire

// File: hdl/fsbm_datapath.sv
// frame stores, address counters, sad pipeline and result register
`default_nettype none

`include "full_search_block_match_unit_assert.svh"

module fsbm_datapath #(
    parameter int FRAME_WIDTH  = fsbm_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = fsbm_pkg::DEF_FRAME_HEIGHT,
    parameter int BLOCK_SIZE   = fsbm_pkg::DEF_BLOCK_SIZE
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire fsbm_pkg::t_fsbm_cmd                 i_cmd,
    output fsbm_pkg::t_fsbm_status                   o_status,
    input  wire logic [fsbm_pkg::CMD_W-1:0]          i_command,
    input  wire logic [fsbm_pkg::PIXEL_ROW_W-1:0]    i_pixel_row,
    input  wire logic [fsbm_pkg::PIXEL_COL_W-1:0]    i_pixel_col,
    input  wire logic [fsbm_pkg::PIXEL_W-1:0]        i_pixel_value,
    input  wire logic [fsbm_pkg::BLOCK_ROW_W-1:0]    i_block_row,
    input  wire logic [fsbm_pkg::BLOCK_COL_W-1:0]    i_block_col,
    input  wire logic                                i_ready,
    output logic                                     o_valid,
    output logic      [fsbm_pkg::MATCH_ROW_W-1:0]    o_match_row,
    output logic      [fsbm_pkg::MATCH_COL_W-1:0]    o_match_col,
    output logic      [fsbm_pkg::MATCH_ROW_W-1:0]    o_current_row,
    output logic      [fsbm_pkg::MATCH_COL_W-1:0]    o_current_col,
    output logic      [fsbm_pkg::BLOCK_NUM_W-1:0]    o_block_number
);

    localparam int BPR     = FRAME_WIDTH / BLOCK_SIZE;
    localparam int BPC     = FRAME_HEIGHT / BLOCK_SIZE;
    localparam int WPR     = (FRAME_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int DEPTH   = FRAME_HEIGHT * WPR;
    localparam int ADDR_W  = fsbm_pkg::clog2_min1(DEPTH);
    localparam int ROW_W   = fsbm_pkg::clog2_min1(FRAME_HEIGHT);
    localparam int COL_W   = fsbm_pkg::clog2_min1(FRAME_WIDTH);
    localparam int LANE_W  = fsbm_pkg::clog2_min1(BLOCK_SIZE);
    localparam int BR_W    = fsbm_pkg::clog2_min1(BPC);
    localparam int BC_W    = fsbm_pkg::clog2_min1(BPR);
    localparam int SUM_W   = fsbm_pkg::clog2_min1(BLOCK_SIZE * fsbm_pkg::PIXEL_MAX + 1);
    localparam int SAD_MX  = fsbm_pkg::clog2_min1(BLOCK_SIZE * BLOCK_SIZE * fsbm_pkg::PIXEL_MAX + 1);
    localparam int BEST_W  = fsbm_pkg::clog2_min1(fsbm_pkg::INITIAL_BEST + 1);
    localparam int SAD_W   = (SAD_MX > BEST_W) ? SAD_MX : BEST_W;
    localparam int PCOL_W  = fsbm_pkg::PIXEL_COL_W;
    localparam int RECIP_S = PCOL_W + 1;
    localparam int RECIP   = (1 << RECIP_S) / BLOCK_SIZE;
    localparam int RECIP_W = RECIP_S + 1;
    localparam int PROD_W  = PCOL_W + RECIP_W;

    logic w_wr_go;
    logic w_srch_go;
    logic w_load_wr;
    logic w_load_srch;

    // write path
    logic [PROD_W-1:0]            w_prod;
    logic [PCOL_W-1:0]            r_wq0;
    logic [PCOL_W-1:0]            r_wcol;
    logic [ADDR_W-1:0]            r_wrow_base;
    logic [fsbm_pkg::PIXEL_W-1:0] r_wval;
    logic                         r_wsel;
    logic [PCOL_W-1:0]            w_rem0;
    logic                         w_fix;
    logic [LANE_W-1:0]            w_lane;
    logic [ADDR_W-1:0]            w_waddr;

    // scan address counters
    logic [LANE_W-1:0] r_m;
    logic [BC_W-1:0]   r_l;
    logic [BR_W-1:0]   r_k;
    logic [ADDR_W-1:0] r_ref_addr;
    logic [ADDR_W-1:0] r_cur_addr;
    logic [ADDR_W-1:0] r_cur_base;

    // sad pipeline
    logic [fsbm_pkg::PIXEL_W-1:0] w_ref_pix [BLOCK_SIZE];
    logic [fsbm_pkg::PIXEL_W-1:0] w_cur_pix [BLOCK_SIZE];
    logic                         r_v1;
    logic                         r_first1;
    logic                         r_last1;
    logic                         r_v2;
    logic                         r_first2;
    logic                         r_last2;
    logic [SUM_W-1:0]             w_rowsum;
    logic [SUM_W-1:0]             r_rowsum;
    logic [SAD_W-1:0]             w_acc;
    logic [SAD_W-1:0]             r_acc;
    logic [SAD_W-1:0]             r_best;
    logic [ROW_W-1:0]             r_best_row;
    logic [COL_W-1:0]             r_best_col;
    logic [ROW_W-1:0]             r_cand_row;
    logic [COL_W-1:0]             r_cand_col;

    // search tags and result register
    logic [fsbm_pkg::MATCH_ROW_W-1:0] r_s_cur_row;
    logic [fsbm_pkg::MATCH_COL_W-1:0] r_s_cur_col;
    logic [fsbm_pkg::BLOCK_NUM_W-1:0] r_s_blk_num;
    logic                             r_out_valid;
    logic [fsbm_pkg::MATCH_ROW_W-1:0] r_match_row;
    logic [fsbm_pkg::MATCH_COL_W-1:0] r_match_col;
    logic [fsbm_pkg::MATCH_ROW_W-1:0] r_cur_row;
    logic [fsbm_pkg::MATCH_COL_W-1:0] r_cur_col;
    logic [fsbm_pkg::BLOCK_NUM_W-1:0] r_blk_num;

    assign w_wr_go = ((i_command == fsbm_pkg::CMD_WR_REF) ||
                      (i_command == fsbm_pkg::CMD_WR_CUR)) &&
                     (int'(i_pixel_row) < FRAME_HEIGHT) && (int'(i_pixel_col) < FRAME_WIDTH);
    assign w_srch_go = (i_command == fsbm_pkg::CMD_SEARCH) &&
                       (int'(i_block_row) < BPC) && (int'(i_block_col) < BPR);
    assign w_load_wr   = i_cmd.load && w_wr_go;
    assign w_load_srch = i_cmd.load && w_srch_go;

    always_comb begin
        o_status.wr_go     = w_wr_go;
        o_status.srch_go   = w_srch_go;
        o_status.scan_last = (r_m == LANE_W'(BLOCK_SIZE - 1)) && (r_l == BC_W'(BPR - 1)) &&
                             (r_k == BR_W'(BPC - 1));
        o_status.pipe_busy = r_v1 || r_v2;
        o_status.out_free  = !r_out_valid || i_ready;
    end

    // column split into word and lane by reciprocal multiply, one correction step
    assign w_prod = PROD_W'(i_pixel_col) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (w_load_wr) begin
            r_wq0       <= PCOL_W'(w_prod >> RECIP_S);
            r_wcol      <= i_pixel_col;
            r_wrow_base <= ADDR_W'(int'(i_pixel_row) * WPR);
            r_wval      <= i_pixel_value;
            r_wsel      <= (i_command == fsbm_pkg::CMD_WR_CUR);
        end
    end

    always_comb begin
        w_rem0  = r_wcol - PCOL_W'(int'(r_wq0) * BLOCK_SIZE);
        w_fix   = (int'(w_rem0) >= BLOCK_SIZE);
        w_lane  = w_fix ? LANE_W'(int'(w_rem0) - BLOCK_SIZE) : LANE_W'(w_rem0);
        w_waddr = r_wrow_base + ADDR_W'(r_wq0) + ADDR_W'(w_fix);
    end

    // one word row of both blocks per cycle
    always_ff @(posedge i_clk) begin
        if (w_load_srch) begin
            r_m        <= '0;
            r_l        <= '0;
            r_k        <= '0;
            r_ref_addr <= '0;
            r_cur_base <= ADDR_W'(int'(i_block_row) * (BLOCK_SIZE * WPR) + int'(i_block_col));
            r_cur_addr <= ADDR_W'(int'(i_block_row) * (BLOCK_SIZE * WPR) + int'(i_block_col));
        end else if (i_cmd.scan_issue) begin
            if (r_m != LANE_W'(BLOCK_SIZE - 1)) begin
                r_m        <= r_m + 1'b1;
                r_ref_addr <= r_ref_addr + ADDR_W'(WPR);
                r_cur_addr <= r_cur_addr + ADDR_W'(WPR);
            end else begin
                r_m        <= '0;
                r_cur_addr <= r_cur_base;
                if (r_l != BC_W'(BPR - 1)) begin
                    r_l        <= r_l + 1'b1;
                    r_ref_addr <= r_ref_addr - ADDR_W'((BLOCK_SIZE - 1) * WPR) + 1'b1;
                end else begin
                    r_l        <= '0;
                    r_k        <= r_k + 1'b1;
                    r_ref_addr <= r_ref_addr + ADDR_W'(WPR) - ADDR_W'(BPR - 1);
                end
            end
        end
    end

    for (genvar g = 0; g < BLOCK_SIZE; g++) begin : g_lane
        fsbm_ram #(
            .WIDTH (fsbm_pkg::PIXEL_W),
            .DEPTH (DEPTH)
        ) u_ref_ram (
            .i_clk   (i_clk),
            .i_we    (i_cmd.wr_commit && !r_wsel && (w_lane == LANE_W'(g))),
            .i_waddr (w_waddr),
            .i_wdata (r_wval),
            .i_re    (i_cmd.scan_issue),
            .i_raddr (r_ref_addr),
            .o_rdata (w_ref_pix[g])
        );

        fsbm_ram #(
            .WIDTH (fsbm_pkg::PIXEL_W),
            .DEPTH (DEPTH)
        ) u_cur_ram (
            .i_clk   (i_clk),
            .i_we    (i_cmd.wr_commit && r_wsel && (w_lane == LANE_W'(g))),
            .i_waddr (w_waddr),
            .i_wdata (r_wval),
            .i_re    (i_cmd.scan_issue),
            .i_raddr (r_cur_addr),
            .o_rdata (w_cur_pix[g])
        );
    end

    always_comb begin
        w_rowsum = '0;
        for (int i = 0; i < BLOCK_SIZE; i++) begin
            if (w_cur_pix[i] > w_ref_pix[i]) begin
                w_rowsum = w_rowsum + SUM_W'(w_cur_pix[i] - w_ref_pix[i]);
            end else begin
                w_rowsum = w_rowsum + SUM_W'(w_ref_pix[i] - w_cur_pix[i]);
            end
        end
    end

    assign w_acc = (r_first2 ? SAD_W'(0) : r_acc) + SAD_W'(r_rowsum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_issue;
            r_v2 <= r_v1;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_issue) begin
            r_first1 <= (r_m == '0);
            r_last1  <= (r_m == LANE_W'(BLOCK_SIZE - 1));
        end
        if (r_v1) begin
            r_rowsum <= w_rowsum;
            r_first2 <= r_first1;
            r_last2  <= r_last1;
        end
    end

    // running sum and strict-less best; candidates arrive in raster order
    always_ff @(posedge i_clk) begin
        if (w_load_srch) begin
            r_best      <= SAD_W'(fsbm_pkg::INITIAL_BEST);
            r_best_row  <= '0;
            r_best_col  <= '0;
            r_cand_row  <= '0;
            r_cand_col  <= '0;
            r_s_cur_row <= fsbm_pkg::MATCH_ROW_W'(int'(i_block_row) * BLOCK_SIZE);
            r_s_cur_col <= fsbm_pkg::MATCH_COL_W'(int'(i_block_col) * BLOCK_SIZE);
            r_s_blk_num <= fsbm_pkg::BLOCK_NUM_W'(int'(i_block_row) * BPR + int'(i_block_col));
        end else if (r_v2) begin
            r_acc <= w_acc;
            if (r_last2) begin
                if (w_acc < r_best) begin
                    r_best     <= w_acc;
                    r_best_row <= r_cand_row;
                    r_best_col <= r_cand_col;
                end
                if (r_cand_col == COL_W'((BPR - 1) * BLOCK_SIZE)) begin
                    r_cand_col <= '0;
                    r_cand_row <= r_cand_row + ROW_W'(BLOCK_SIZE);
                end else begin
                    r_cand_col <= r_cand_col + COL_W'(BLOCK_SIZE);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_match_row <= fsbm_pkg::MATCH_ROW_W'(r_best_row);
            r_match_col <= fsbm_pkg::MATCH_COL_W'(r_best_col);
            r_cur_row   <= r_s_cur_row;
            r_cur_col   <= r_s_cur_col;
            r_blk_num   <= r_s_blk_num;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_match_row    = r_match_row;
    assign o_match_col    = r_match_col;
    assign o_current_row  = r_cur_row;
    assign o_current_col  = r_cur_col;
    assign o_block_number = r_blk_num;

    `FSBM_ASSERT_NEXT(a_best_never_grows, i_clk, i_rst_n, r_v2, r_best <= $past(r_best))

endmodule

`default_nettype wire

// File: hdl/full_search_block_match_unit.sv
// full search block matching unit, sum of absolute differences over whole blocks
//
// input channel (i_valid / o_ready): one command per beat. a reference or
// current pixel write is stored and gives no result. a search names one
// block of the current frame and compares it with every block-aligned block
// of the reference frame. out-of-frame writes, out-of-frame searches and the
// unused command are taken and dropped.
// a search reads one row of BLOCK_SIZE pixels from both frame stores per
// cycle through BLOCK_SIZE lane rams each, scans every candidate block and
// then drains the sad pipeline before the result is loaded.
// one item is in work at a time.
// output channel (o_valid / i_ready): one beat per search with match and
// current positions and the block number, held in an output register. while
// it waits, writes go on; a following search finishes its scan and then
// waits for the register to free.
// reset clears the sequencer, the pipeline valids and the output valid; the frame stores are not
// cleared and must be written before they are searched.
`default_nettype none

module full_search_block_match_unit #(
    parameter int FRAME_WIDTH  = fsbm_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = fsbm_pkg::DEF_FRAME_HEIGHT,
    parameter int BLOCK_SIZE   = fsbm_pkg::DEF_BLOCK_SIZE
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [fsbm_pkg::CMD_W-1:0]       i_command,
    input  wire logic [fsbm_pkg::PIXEL_ROW_W-1:0] i_pixel_row,
    input  wire logic [fsbm_pkg::PIXEL_COL_W-1:0] i_pixel_col,
    input  wire logic [fsbm_pkg::PIXEL_W-1:0]     i_pixel_value,
    input  wire logic [fsbm_pkg::BLOCK_ROW_W-1:0] i_block_row,
    input  wire logic [fsbm_pkg::BLOCK_COL_W-1:0] i_block_col,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic      [fsbm_pkg::MATCH_ROW_W-1:0] o_match_row,
    output logic      [fsbm_pkg::MATCH_COL_W-1:0] o_match_col,
    output logic      [fsbm_pkg::MATCH_ROW_W-1:0] o_current_row,
    output logic      [fsbm_pkg::MATCH_COL_W-1:0] o_current_col,
    output logic      [fsbm_pkg::BLOCK_NUM_W-1:0] o_block_number
);

    fsbm_pkg::t_fsbm_cmd    w_cmd;
    fsbm_pkg::t_fsbm_status w_status;

    fsbm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    fsbm_datapath #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .BLOCK_SIZE   (BLOCK_SIZE)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_command      (i_command),
        .i_pixel_row    (i_pixel_row),
        .i_pixel_col    (i_pixel_col),
        .i_pixel_value  (i_pixel_value),
        .i_block_row    (i_block_row),
        .i_block_col    (i_block_col),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_match_row    (o_match_row),
        .o_match_col    (o_match_col),
        .o_current_row  (o_current_row),
        .o_current_col  (o_current_col),
        .o_block_number (o_block_number)
    );

endmodule

`default_nettype wire

// File: test/testbench.sv
// self-checking testbench for the full search block match unit
`timescale 1ns / 1ps

module testbench;

    localparam int FRAME_W     = fsbm_pkg::DEF_FRAME_WIDTH;
    localparam int FRAME_H     = fsbm_pkg::DEF_FRAME_HEIGHT;
    localparam int BLK         = fsbm_pkg::DEF_BLOCK_SIZE;
    localparam int BLK_COLS    = FRAME_W / BLK;
    localparam int BLK_ROWS    = FRAME_H / BLK;
    localparam int FRAME_PIX   = FRAME_W * FRAME_H;
    localparam int SETTLE_CYC  = 30000;
    localparam int RAND_SRCH   = 30;

    localparam logic [fsbm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // reference blocks zero, full, and a random twin with its copy, given as block row and column
    localparam int ZERO_BR  = 0;
    localparam int ZERO_BC  = 1;
    localparam int FULL_BR  = 2;
    localparam int FULL_BC  = 3;
    localparam int TWIN_BR  = 10;
    localparam int TWIN_BC  = 20;
    localparam int COPY_BR  = 30;
    localparam int COPY_BC  = 70;

    typedef enum int {FILL_LEVEL, FILL_RANDOM, FILL_COPY, FILL_NEAR} t_fill_kind;

    typedef struct packed {
        logic [fsbm_pkg::CMD_W-1:0]       command;
        logic [fsbm_pkg::PIXEL_ROW_W-1:0] pixel_row;
        logic [fsbm_pkg::PIXEL_COL_W-1:0] pixel_col;
        logic [fsbm_pkg::PIXEL_W-1:0]     pixel_value;
        logic [fsbm_pkg::BLOCK_ROW_W-1:0] block_row;
        logic [fsbm_pkg::BLOCK_COL_W-1:0] block_col;
    } t_beat;

    typedef struct packed {
        logic [fsbm_pkg::MATCH_ROW_W-1:0] match_row;
        logic [fsbm_pkg::MATCH_COL_W-1:0] match_col;
        logic [fsbm_pkg::MATCH_ROW_W-1:0] current_row;
        logic [fsbm_pkg::MATCH_COL_W-1:0] current_col;
        logic [fsbm_pkg::BLOCK_NUM_W-1:0] block_number;
    } t_match;

    class t_match_board;
        bit [7:0] ref_luma [FRAME_PIX];
        bit [7:0] cur_luma [FRAME_PIX];
        t_match   awaited_matches [$];
        int       errors;
        int       beats_seen;
        int       results_seen;

        function t_match best_match(int brow, int bcol);
            t_match res;
            int     cr, cc, rr, rc, sad, best, best_r, best_c, a, b;
            cr = brow * BLK;
            cc = bcol * BLK;
            best = fsbm_pkg::INITIAL_BEST;
            best_r = 0;
            best_c = 0;
            for (int k = 0; k < BLK_ROWS; k++) begin
                for (int l = 0; l < BLK_COLS; l++) begin
                    rr = k * BLK;
                    rc = l * BLK;
                    sad = 0;
                    for (int m = 0; m < BLK; m++) begin
                        for (int n = 0; n < BLK; n++) begin
                            a = int'(cur_luma[(cr + m) * FRAME_W + cc + n]);
                            b = int'(ref_luma[(rr + m) * FRAME_W + rc + n]);
                            sad += (a > b) ? (a - b) : (b - a);
                        end
                    end
                    if (sad < best) begin
                        best = sad;
                        best_r = rr;
                        best_c = rc;
                    end
                end
            end
            res.match_row    = fsbm_pkg::MATCH_ROW_W'(best_r);
            res.match_col    = fsbm_pkg::MATCH_COL_W'(best_c);
            res.current_row  = fsbm_pkg::MATCH_ROW_W'(cr);
            res.current_col  = fsbm_pkg::MATCH_COL_W'(cc);
            res.block_number = fsbm_pkg::BLOCK_NUM_W'(brow * BLK_COLS + bcol);
            return res;
        endfunction

        function void note_beat(t_beat b);
            int addr;
            beats_seen++;
            case (b.command)
                fsbm_pkg::CMD_WR_REF, fsbm_pkg::CMD_WR_CUR: begin
                    if (b.pixel_row < FRAME_H && b.pixel_col < FRAME_W) begin
                        addr = int'(b.pixel_row) * FRAME_W + int'(b.pixel_col);
                        if (b.command == fsbm_pkg::CMD_WR_REF)
                            ref_luma[addr] = b.pixel_value;
                        else
                            cur_luma[addr] = b.pixel_value;
                    end
                end
                fsbm_pkg::CMD_SEARCH: begin
                    if (b.block_row < BLK_ROWS && b.block_col < BLK_COLS)
                        awaited_matches.push_back(best_match(int'(b.block_row),
                                                             int'(b.block_col)));
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_match got);
            t_match want;
            results_seen++;
            if (awaited_matches.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: match (%0d,%0d) block (%0d,%0d) number %0d",
                             got.match_row, got.match_col, got.current_row,
                             got.current_col, got.block_number);
                return;
            end
            want = awaited_matches.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected match (%0d,%0d) block (%0d,%0d) number %0d,",
                              " got match (%0d,%0d) block (%0d,%0d) number %0d"},
                             want.match_row, want.match_col, want.current_row,
                             want.current_col, want.block_number,
                             got.match_row, got.match_col, got.current_row,
                             got.current_col, got.block_number);
            end
        endfunction

        function int pending();
            return awaited_matches.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready;
    logic o_valid;
    logic [fsbm_pkg::CMD_W-1:0]       i_command     = '0;
    logic [fsbm_pkg::PIXEL_ROW_W-1:0] i_pixel_row   = '0;
    logic [fsbm_pkg::PIXEL_COL_W-1:0] i_pixel_col   = '0;
    logic [fsbm_pkg::PIXEL_W-1:0]     i_pixel_value = '0;
    logic [fsbm_pkg::BLOCK_ROW_W-1:0] i_block_row   = '0;
    logic [fsbm_pkg::BLOCK_COL_W-1:0] i_block_col   = '0;
    logic [fsbm_pkg::MATCH_ROW_W-1:0] o_match_row;
    logic [fsbm_pkg::MATCH_COL_W-1:0] o_match_col;
    logic [fsbm_pkg::MATCH_ROW_W-1:0] o_current_row;
    logic [fsbm_pkg::MATCH_COL_W-1:0] o_current_col;
    logic [fsbm_pkg::BLOCK_NUM_W-1:0] o_block_number;
    t_match seen_match;

    t_match_board sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int searchable [$];

    full_search_block_match_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_pixel_row    (i_pixel_row),
        .i_pixel_col    (i_pixel_col),
        .i_pixel_value  (i_pixel_value),
        .i_block_row    (i_block_row),
        .i_block_col    (i_block_col),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_match_row    (o_match_row),
        .o_match_col    (o_match_col),
        .o_current_row  (o_current_row),
        .o_current_col  (o_current_col),
        .o_block_number (o_block_number)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    assign seen_match = {o_match_row, o_match_col, o_current_row, o_current_col, o_block_number};

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(seen_match);
    end

    function automatic t_beat random_beat();
        t_beat b;
        b.command     = fsbm_pkg::CMD_W'($urandom_range(3));
        b.pixel_row   = fsbm_pkg::PIXEL_ROW_W'($urandom);
        b.pixel_col   = fsbm_pkg::PIXEL_COL_W'($urandom);
        b.pixel_value = fsbm_pkg::PIXEL_W'($urandom);
        b.block_row   = fsbm_pkg::BLOCK_ROW_W'($urandom);
        b.block_col   = fsbm_pkg::BLOCK_COL_W'($urandom);
        return b;
    endfunction

    task automatic send_beat(t_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= b.command;
        i_pixel_row   <= b.pixel_row;
        i_pixel_col   <= b.pixel_col;
        i_pixel_value <= b.pixel_value;
        i_block_row   <= b.block_row;
        i_block_col   <= b.block_col;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_beat(b);
    endtask

    task automatic write_pixel(logic [fsbm_pkg::CMD_W-1:0] cmd, int r, int c, int v);
        t_beat b;
        b = random_beat();
        b.command     = cmd;
        b.pixel_row   = fsbm_pkg::PIXEL_ROW_W'(r);
        b.pixel_col   = fsbm_pkg::PIXEL_COL_W'(c);
        b.pixel_value = fsbm_pkg::PIXEL_W'(v);
        send_beat(b);
    endtask

    task automatic search_block(int br, int bc);
        t_beat b;
        b = random_beat();
        b.command   = fsbm_pkg::CMD_SEARCH;
        b.block_row = fsbm_pkg::BLOCK_ROW_W'(br);
        b.block_col = fsbm_pkg::BLOCK_COL_W'(bc);
        send_beat(b);
    endtask

    // out-of-frame writes and searches, the unused command, stray reference writes
    task automatic send_noise();
        t_beat b;
        b = random_beat();
        case ($urandom_range(5))
            0: begin
                b.command   = $urandom_range(1) ? fsbm_pkg::CMD_WR_CUR : fsbm_pkg::CMD_WR_REF;
                b.pixel_row = fsbm_pkg::PIXEL_ROW_W'($urandom_range(511, FRAME_H));
            end
            1: begin
                b.command   = $urandom_range(1) ? fsbm_pkg::CMD_WR_CUR : fsbm_pkg::CMD_WR_REF;
                b.pixel_col = fsbm_pkg::PIXEL_COL_W'($urandom_range(1023, FRAME_W));
            end
            2: b.command = CMD_UNUSED;
            3: begin
                b.command   = fsbm_pkg::CMD_SEARCH;
                b.block_row = fsbm_pkg::BLOCK_ROW_W'($urandom_range(63, BLK_ROWS));
            end
            4: begin
                b.command   = fsbm_pkg::CMD_SEARCH;
                b.block_col = fsbm_pkg::BLOCK_COL_W'($urandom_range(127, BLK_COLS));
            end
            default: begin
                b.command   = fsbm_pkg::CMD_WR_REF;
                b.pixel_row = fsbm_pkg::PIXEL_ROW_W'($urandom_range(FRAME_H - 1));
                b.pixel_col = fsbm_pkg::PIXEL_COL_W'($urandom_range(FRAME_W - 1));
            end
        endcase
        send_beat(b);
    endtask

    function automatic int ref_fill_value(int r, int c);
        int br, bc;
        br = r / BLK;
        bc = c / BLK;
        if (br == ZERO_BR && bc == ZERO_BC)
            return 0;
        if (br == FULL_BR && bc == FULL_BC)
            return fsbm_pkg::PIXEL_MAX;
        if (br == COPY_BR && bc == COPY_BC)
            return int'(sb.ref_luma[(r - (COPY_BR - TWIN_BR) * BLK) * FRAME_W
                                    + c - (COPY_BC - TWIN_BC) * BLK]);
        return $urandom_range(fsbm_pkg::PIXEL_MAX);
    endfunction

    task automatic load_cur_block(int br, int bc, t_fill_kind kind, int level, int noise_pct);
        int sr, sc, v;
        sr = $urandom_range(BLK_ROWS - 1) * BLK;
        sc = $urandom_range(BLK_COLS - 1) * BLK;
        if (kind == FILL_COPY && level >= 0) begin
            sr = (level / BLK_COLS) * BLK;
            sc = (level % BLK_COLS) * BLK;
        end
        for (int m = 0; m < BLK; m++) begin
            for (int n = 0; n < BLK; n++) begin
                case (kind)
                    FILL_LEVEL:  v = level;
                    FILL_RANDOM: v = $urandom_range(fsbm_pkg::PIXEL_MAX);
                    FILL_COPY:   v = int'(sb.ref_luma[(sr + m) * FRAME_W + sc + n]);
                    default: begin
                        v = int'(sb.ref_luma[(sr + m) * FRAME_W + sc + n])
                            + int'($urandom_range(6)) - 3;
                        if (v < 0) v = 0;
                        if (v > fsbm_pkg::PIXEL_MAX) v = fsbm_pkg::PIXEL_MAX;
                    end
                endcase
                write_pixel(fsbm_pkg::CMD_WR_CUR, br * BLK + m, bc * BLK + n, v);
                if ($urandom_range(99) < noise_pct)
                    send_noise();
            end
        end
        searchable.push_back(br * BLK_COLS + bc);
    endtask

    task automatic set_phase(int ph);
        case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
    endtask

    initial begin
        int rand_searches, idx, br, bc, pick;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full reference frame, then a few fixed current blocks
        set_phase(0);
        for (int r = 0; r < FRAME_H; r++)
            for (int c = 0; c < FRAME_W; c++)
                write_pixel(fsbm_pkg::CMD_WR_REF, r, c, ref_fill_value(r, c));
        load_cur_block(0, 0, FILL_LEVEL, 0, 0);
        load_cur_block(BLK_ROWS - 1, BLK_COLS - 1, FILL_LEVEL, fsbm_pkg::PIXEL_MAX, 0);
        load_cur_block(5, 5, FILL_COPY, TWIN_BR * BLK_COLS + TWIN_BC, 0);

        set_phase(3);
        write_pixel(fsbm_pkg::CMD_WR_REF, FRAME_H, 5, 'hAA);
        write_pixel(fsbm_pkg::CMD_WR_REF, 511, 1023, 'h55);
        write_pixel(fsbm_pkg::CMD_WR_CUR, 0, FRAME_W, 'hFF);
        write_pixel(fsbm_pkg::CMD_WR_CUR, FRAME_H - 1, 1023, 0);
        write_pixel(CMD_UNUSED, 511, 1023, 'hFF);
        search_block(BLK_ROWS, 0);
        search_block(63, 127);
        search_block(0, BLK_COLS);
        search_block(0, 0);
        search_block(BLK_ROWS - 1, BLK_COLS - 1);
        // equal candidates: the earlier one in raster order wins
        search_block(5, 5);
        write_pixel(fsbm_pkg::CMD_WR_REF, FRAME_H - 1, FRAME_W - 1, fsbm_pkg::PIXEL_MAX);
        write_pixel(fsbm_pkg::CMD_WR_REF, 0, 0, 0);
        write_pixel(fsbm_pkg::CMD_WR_CUR, 0, 0, fsbm_pkg::PIXEL_MAX);
        search_block(0, 0);
        // break the tie so the later twin wins
        write_pixel(fsbm_pkg::CMD_WR_REF, TWIN_BR * BLK, TWIN_BC * BLK,
                    fsbm_pkg::PIXEL_MAX
                    - int'(sb.ref_luma[TWIN_BR * BLK * FRAME_W + TWIN_BC * BLK]));
        search_block(5, 5);

        rand_searches = 0;
        while (rand_searches < RAND_SRCH) begin
            set_phase(rand_searches / 4);
            pick = $urandom_range(99);
            if (pick < 55) begin
                br = $urandom_range(BLK_ROWS - 1);
                bc = $urandom_range(BLK_COLS - 1);
                load_cur_block(br, bc, t_fill_kind'($urandom_range(3)),
                               $urandom_range(fsbm_pkg::PIXEL_MAX) - 1, 5);
                search_block(br, bc);
                rand_searches++;
            end else if (pick < 75) begin
                idx = searchable[$urandom_range(searchable.size() - 1)];
                br = idx / BLK_COLS;
                bc = idx % BLK_COLS;
                repeat ($urandom_range(4, 1))
                    write_pixel(fsbm_pkg::CMD_WR_CUR, br * BLK + $urandom_range(BLK - 1),
                                bc * BLK + $urandom_range(BLK - 1),
                                $urandom_range(fsbm_pkg::PIXEL_MAX));
                repeat ($urandom_range(3))
                    write_pixel(fsbm_pkg::CMD_WR_REF, $urandom_range(FRAME_H - 1),
                                $urandom_range(FRAME_W - 1),
                                $urandom_range(fsbm_pkg::PIXEL_MAX));
                search_block(br, bc);
                rand_searches++;
            end else begin
                repeat ($urandom_range(6, 1))
                    send_noise();
            end
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("summary: %0d beats accepted, %0d search results checked, %0d errors",
                 sb.beats_seen, sb.results_seen, sb.errors);
        $display("summary: full reference fill, fixed and random blocks, four idle mixes");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/fsbm_pkg.sv
hdl/fsbm_ram.sv
hdl/fsbm_ctrl.sv
hdl/fsbm_datapath.sv
hdl/full_search_block_match_unit.sv
test/testbench.sv
